[hdl/ers_pkg.sv]
// shared constants, codes and beat types of the record store
// no dependencies
package ers_pkg;

    localparam int STORE_SIZE_DEF = 1024;
    localparam int MAX_LEN_DEF    = 64;
    localparam int STAGE_DEPTH    = 64;
    localparam int POS_W          = 18;

    localparam logic [7:0] MARK_START   = 8'h21;
    localparam logic [7:0] MARK_END     = 8'h24;
    localparam logic [7:0] MARK_FREE    = 8'h00;
    localparam int         HDR_BYTES    = 5;
    localparam int         APPEND_SLACK = 6;

    localparam logic [1:0] KIND_STAGE  = 2'd0;
    localparam logic [1:0] KIND_COMMIT = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_FREE   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_NOSPACE  = 2'd2;
    localparam logic [1:0] ST_TOOLONG  = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  data_out;
        logic        byte_valid;
        logic [15:0] stored_length;
    } rsp_t;

endpackage

[hdl/ers_if.sv]
// request and response channels of the record store
// no dependencies
interface ers_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] record_id;
    logic [6:0]  record_length;
    logic [5:0]  byte_index;
    logic [7:0]  data_in;

    modport source (output valid, kind, record_id, record_length, byte_index, data_in,
                    input ready);
    modport sink   (input valid, kind, record_id, record_length, byte_index, data_in,
                    output ready);
endinterface

interface ers_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  data_out;
    logic        byte_valid;
    logic [15:0] stored_length;

    modport source (output valid, status, data_out, byte_valid, stored_length,
                    input ready);
    modport sink   (input valid, status, data_out, byte_valid, stored_length,
                    output ready);
endinterface

[hdl/ers_ram.sv]
// generic simple dual port ram, registered read
// no dependencies
module ers_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/eeprom_record_store.sv]
// tagged record store over one byte ram and one staging ram
// depends on ers_pkg, ers_if, ers_ram
// a commit may scan the store twice
// throughput: one request at a time, set by the single read port of the byte ram
// reset: after rst_n the byte ram is cleared, one byte a cycle, all STORE_SIZE bytes,
// during which no request is taken; staging ram is not cleared
module eeprom_record_store
    import ers_pkg::*;
#(
    parameter int STORE_SIZE = STORE_SIZE_DEF,
    parameter int MAX_LEN    = MAX_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ers_req_if.sink    in_ch,
    ers_rsp_if.source  out_ch
);

    localparam int AW = $clog2(STORE_SIZE);
    localparam int SW = $clog2(STAGE_DEPTH);
    localparam logic [POS_W-1:0] SIZE_P = POS_W'(STORE_SIZE);
    localparam logic [10:0] MAXLEN_P = 11'(MAX_LEN);
    localparam logic [AW-1:0] CLR_LAST = AW'(STORE_SIZE - 1);

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_B0A  = 5'd2;
    localparam logic [4:0] S_B0D  = 5'd3;
    localparam logic [4:0] S_SCA  = 5'd4;
    localparam logic [4:0] S_SCD  = 5'd5;
    localparam logic [4:0] S_HDA  = 5'd6;
    localparam logic [4:0] S_HDD  = 5'd7;
    localparam logic [4:0] S_RBA  = 5'd8;
    localparam logic [4:0] S_RBD  = 5'd9;
    localparam logic [4:0] S_FRW  = 5'd10;
    localparam logic [4:0] S_RMA  = 5'd11;
    localparam logic [4:0] S_RMD  = 5'd12;
    localparam logic [4:0] S_HW   = 5'd13;
    localparam logic [4:0] S_CPA  = 5'd14;
    localparam logic [4:0] S_CPD  = 5'd15;
    localparam logic [4:0] S_ENDW = 5'd16;
    localparam logic [4:0] S_DONE = 5'd17;

    logic [4:0]       state_reg, state_next;
    logic [1:0]       kind_reg;
    logic [15:0]      id_reg;
    logic [6:0]       len_reg;
    logic [5:0]       idx_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic [31:0]      hdr_reg, hdr_next;
    logic             endmode_reg, endmode_next;
    logic             append_reg, append_next;
    rsp_t             work_reg, work_next;
    rsp_t             out_reg;
    logic             out_valid_reg;
    logic [AW-1:0]    clr_reg;
    logic             oob_reg;

    logic [POS_W-1:0] rd_pos, wr_pos;
    logic             wr_en;
    logic [7:0]       wr_data;
    logic [7:0]       st_rdata, stg_rdata, rbyte;
    logic             st_we;
    logic [AW-1:0]    st_waddr;
    logic [7:0]       st_wdata;
    logic             in_fire;
    logic [31:0]      hdr_full;
    logic [POS_W-1:0] e_pos, sum_space, rec_next;
    logic [7:0]       hw_byte;

    assign in_ch.ready   = (state_reg == S_IDLE);
    assign in_fire       = in_ch.valid && in_ch.ready;
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.status        = out_reg.status;
    assign out_ch.data_out      = out_reg.data_out;
    assign out_ch.byte_valid    = out_reg.byte_valid;
    assign out_ch.stored_length = out_reg.stored_length;

    assign rbyte    = oob_reg ? 8'd0 : st_rdata;
    assign hdr_full = {rbyte, hdr_reg[23:0]};
    assign rec_next = pos_reg + POS_W'(HDR_BYTES) + POS_W'(hdr_full[31:16]);
    assign sum_space = e_pos + POS_W'(len_reg) + POS_W'(APPEND_SLACK);

    always_comb
    begin
        case (cnt_reg[2:0])
            3'd0:    hw_byte = MARK_START;
            3'd1:    hw_byte = id_reg[7:0];
            3'd2:    hw_byte = id_reg[15:8];
            3'd3:    hw_byte = {1'b0, len_reg};
            default: hw_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        hdr_next     = hdr_reg;
        endmode_next = endmode_reg;
        append_next  = append_reg;
        work_next    = work_reg;
        rd_pos       = pos_reg;
        wr_en        = 1'b0;
        wr_pos       = pos_reg;
        wr_data      = MARK_FREE;
        e_pos        = '0;
        case (state_reg)
            S_CLR:
            begin
                wr_en  = 1'b1;
                wr_pos = POS_W'(clr_reg);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    work_next    = '0;
                    endmode_next = 1'b0;
                    append_next  = 1'b0;
                    if (in_ch.kind == KIND_STAGE)
                    begin
                        state_next = S_DONE;
                    end
                    else if (in_ch.kind == KIND_COMMIT &&
                             {4'd0, in_ch.record_length} > MAXLEN_P)
                    begin
                        work_next.status = ST_TOOLONG;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        state_next = S_B0A;
                    end
                end
            end
            S_B0A:
            begin
                rd_pos     = '0;
                state_next = S_B0D;
            end
            S_B0D:
            begin
                pos_next = '0;
                if (rbyte != MARK_START && rbyte != MARK_END)
                begin
                    wr_en   = 1'b1;
                    wr_pos  = '0;
                    wr_data = MARK_END;
                    if (kind_reg == KIND_COMMIT)
                    begin
                        endmode_next = 1'b1;
                        state_next   = S_SCA;
                    end
                    else
                    begin
                        work_next.status = ST_NOTFOUND;
                        state_next       = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_SCA;
                end
            end
            S_SCA, S_SCD:
            begin
                if (state_reg == S_SCA && pos_reg < SIZE_P)
                begin
                    state_next = S_SCD;
                end
                else if (state_reg == S_SCD && rbyte == MARK_START)
                begin
                    cnt_next   = '0;
                    state_next = S_HDA;
                end
                else if (state_reg == S_SCD && rbyte != MARK_END)
                begin
                    pos_next   = pos_reg + POS_W'(1);
                    state_next = S_SCA;
                end
                else if (endmode_reg)
                begin
                    e_pos = (state_reg == S_SCD) ? pos_reg : '0;
                    if (sum_space < SIZE_P)
                    begin
                        pos_next    = e_pos;
                        append_next = 1'b1;
                        cnt_next    = '0;
                        state_next  = S_HW;
                    end
                    else
                    begin
                        work_next.status = ST_NOSPACE;
                        state_next       = S_DONE;
                    end
                end
                else if (kind_reg == KIND_COMMIT)
                begin
                    endmode_next = 1'b1;
                    pos_next     = '0;
                    state_next   = S_SCA;
                end
                else
                begin
                    work_next.status = ST_NOTFOUND;
                    state_next       = S_DONE;
                end
            end
            S_HDA:
            begin
                rd_pos     = pos_reg + POS_W'(1) + POS_W'(cnt_reg);
                state_next = S_HDD;
            end
            S_HDD:
            begin
                hdr_next[cnt_reg[1:0]*8 +: 8] = rbyte;
                if (cnt_reg[1:0] != 2'd3)
                begin
                    cnt_next   = cnt_reg + 7'd1;
                    state_next = S_HDA;
                end
                else if (!endmode_reg && hdr_full[15:0] == id_reg)
                begin
                    cnt_next = '0;
                    case (kind_reg)
                        KIND_READ:
                        begin
                            work_next.stored_length = hdr_full[31:16];
                            if ({1'b0, idx_reg} < len_reg &&
                                {10'd0, idx_reg} < hdr_full[31:16])
                            begin
                                state_next = S_RBA;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        KIND_FREE:
                        begin
                            state_next = S_FRW;
                        end
                        default:
                        begin
                            if (hdr_full[31:16] == {9'd0, len_reg})
                            begin
                                state_next = S_CPA;
                            end
                            else if ({9'd0, len_reg} < hdr_full[31:16])
                            begin
                                cnt_next   = 7'd3;
                                state_next = S_HW;
                            end
                            else
                            begin
                                state_next = S_RMA;
                            end
                        end
                    endcase
                end
                else
                begin
                    pos_next   = rec_next;
                    state_next = S_SCA;
                end
            end
            S_RBA:
            begin
                rd_pos     = pos_reg + POS_W'(HDR_BYTES) + POS_W'(idx_reg);
                state_next = S_RBD;
            end
            S_RBD:
            begin
                work_next.data_out   = rbyte;
                work_next.byte_valid = 1'b1;
                state_next           = S_DONE;
            end
            S_FRW:
            begin
                wr_en      = 1'b1;
                state_next = S_DONE;
            end
            S_RMA, S_RMD:
            begin
                rd_pos = pos_reg + POS_W'(HDR_BYTES) + POS_W'(cnt_reg);
                if (state_reg == S_RMA && cnt_reg == len_reg)
                begin
                    cnt_next   = 7'd3;
                    state_next = S_HW;
                end
                else if ((state_reg == S_RMA && rd_pos >= SIZE_P) ||
                         (state_reg == S_RMD && rbyte == MARK_START))
                begin
                    wr_en        = 1'b1;
                    wr_pos       = pos_reg;
                    endmode_next = 1'b1;
                    pos_next     = '0;
                    state_next   = S_SCA;
                end
                else if (state_reg == S_RMA)
                begin
                    state_next = S_RMD;
                end
                else
                begin
                    cnt_next   = cnt_reg + 7'd1;
                    state_next = S_RMA;
                end
            end
            S_HW:
            begin
                wr_en   = 1'b1;
                wr_pos  = pos_reg + POS_W'(cnt_reg);
                wr_data = hw_byte;
                if (cnt_reg[2:0] == 3'd4)
                begin
                    cnt_next   = '0;
                    state_next = S_CPA;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            S_CPA:
            begin
                if (cnt_reg == len_reg)
                begin
                    state_next = append_reg ? S_ENDW : S_DONE;
                end
                else
                begin
                    state_next = S_CPD;
                end
            end
            S_CPD:
            begin
                wr_en      = 1'b1;
                wr_pos     = pos_reg + POS_W'(HDR_BYTES) + POS_W'(cnt_reg);
                wr_data    = stg_rdata;
                cnt_next   = cnt_reg + 7'd1;
                state_next = S_CPA;
            end
            S_ENDW:
            begin
                wr_en      = 1'b1;
                wr_pos     = pos_reg + POS_W'(HDR_BYTES) + POS_W'(len_reg);
                wr_data    = MARK_END;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign st_we    = wr_en && (wr_pos < SIZE_P);
    assign st_waddr = wr_pos[AW-1:0];
    assign st_wdata = wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (state_reg == S_DONE && state_next == S_IDLE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        cnt_reg     <= cnt_next;
        hdr_reg     <= hdr_next;
        endmode_reg <= endmode_next;
        append_reg  <= append_next;
        work_reg    <= work_next;
        oob_reg     <= (rd_pos >= SIZE_P);
        if (in_fire)
        begin
            kind_reg <= in_ch.kind;
            id_reg   <= in_ch.record_id;
            len_reg  <= in_ch.record_length;
            idx_reg  <= in_ch.byte_index;
        end
        if (state_reg == S_DONE && state_next == S_IDLE)
        begin
            out_reg <= work_reg;
        end
    end

    ers_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (rd_pos[AW-1:0]),
        .rdata (st_rdata)
    );

    ers_ram #(
        .WIDTH (8),
        .DEPTH (STAGE_DEPTH)
    ) u_stage (
        .clk   (clk),
        .we    (in_fire && in_ch.kind == KIND_STAGE),
        .waddr (in_ch.byte_index[SW-1:0]),
        .wdata (in_ch.data_in),
        .raddr (cnt_reg[SW-1:0]),
        .rdata (stg_rdata)
    );

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !in_ch.ready)
        else $error("request taken during clear pass");

    a_valid_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.byte_valid) |-> (out_reg.status == ST_OK))
        else $error("byte_valid with error status");

    a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && state_next == S_IDLE) |=> out_valid_reg)
        else $error("finished request did not reach output");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HW && append_reg) |-> (wr_pos < SIZE_P))
        else $error("append header outside store");

endmodule

[tb/eeprom_record_store_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench of eeprom_record_store: directed and random requests
// against a built-in record store predictor, random gaps and stalls on both channels
// depends on ers_pkg, ers_if and the eeprom_record_store rtl
module eeprom_record_store_tb;
    import ers_pkg::*;

    class record_scoreboard;
        logic [7:0] store_mem [STORE_SIZE_DEF];
        logic [7:0] staged [STAGE_DEPTH];
        rsp_t       expected_rsp [$];
        int         errors;

        function new();
            foreach (store_mem[i])
                store_mem[i] = 8'h00;
            foreach (staged[i])
                staged[i] = 8'h00;
            errors = 0;
        endfunction

        function int rd8(int a);
            return (a >= 0 && a < STORE_SIZE_DEF) ? int'(store_mem[a]) : 0;
        endfunction

        function int rd16(int a);
            return rd8(a) | (rd8(a + 1) << 8);
        endfunction

        function void wr8(int a, int v);
            if (a >= 0 && a < STORE_SIZE_DEF)
                store_mem[a] = v[7:0];
        endfunction

        function void wr16(int a, int v);
            wr8(a, v);
            wr8(a + 1, v >> 8);
        endfunction

        function bit find_record(int id, output int data_at, output int len);
            int first;
            int pos;
            int mark;
            data_at = 0;
            len = 0;
            first = rd8(0);
            pos = 0;
            if (first != MARK_START && first != MARK_END)
            begin
                wr8(0, MARK_END);
                return 0;
            end
            while (pos < STORE_SIZE_DEF)
            begin
                mark = rd8(pos);
                if (mark == MARK_START)
                begin
                    if (rd16(pos + 1) == id)
                    begin
                        data_at = pos + HDR_BYTES;
                        len = rd16(pos + 3);
                        return 1;
                    end
                    pos = pos + HDR_BYTES + rd16(pos + 3);
                end
                else if (mark == MARK_END)
                    return 0;
                else
                    pos++;
            end
            return 0;
        endfunction

        function int list_end();
            int pos;
            int mark;
            pos = 0;
            while (pos < STORE_SIZE_DEF)
            begin
                mark = rd8(pos);
                if (mark == MARK_START)
                    pos = pos + HDR_BYTES + rd16(pos + 3);
                else if (mark == MARK_END)
                    return pos;
                else
                    pos++;
            end
            return 0;
        endfunction

        function bit fits_in_place(int start, int len);
            for (int i = 0; i < len; i++)
            begin
                if (start + i >= STORE_SIZE_DEF)
                    return 0;
                if (rd8(start + i) == MARK_START)
                    return 0;
            end
            return 1;
        endfunction

        function void copy_staged(int start, int len);
            for (int i = 0; i < len; i++)
                wr8(start + i, staged[i % STAGE_DEPTH]);
        endfunction

        function logic [1:0] commit_record(int id, int len);
            int d;
            int slen;
            int e;
            if (len > MAX_LEN_DEF)
                return ST_TOOLONG;
            if (find_record(id, d, slen))
            begin
                if (slen == len)
                begin
                    copy_staged(d, len);
                    return ST_OK;
                end
                if (len < slen || fits_in_place(d, len))
                begin
                    wr16(d - 2, len);
                    copy_staged(d, len);
                    return ST_OK;
                end
                wr8(d - HDR_BYTES, MARK_FREE);
            end
            e = list_end();
            if (e + len + APPEND_SLACK < STORE_SIZE_DEF)
            begin
                wr8(e, MARK_START);
                wr16(e + 1, id);
                wr16(e + 3, len);
                copy_staged(e + HDR_BYTES, len);
                wr8(e + HDR_BYTES + len, MARK_END);
                return ST_OK;
            end
            return ST_NOSPACE;
        endfunction

        function void note_request(logic [1:0] kind, logic [15:0] id, logic [6:0] len,
                                   logic [5:0] idx, logic [7:0] din);
            rsp_t r;
            int d;
            int slen;
            r = '0;
            case (kind)
                KIND_STAGE:  staged[idx] = din;
                KIND_COMMIT: r.status = commit_record(int'(id), int'(len));
                KIND_READ:
                begin
                    if (find_record(int'(id), d, slen))
                    begin
                        r.stored_length = slen[15:0];
                        if (idx < len && int'(idx) < slen)
                        begin
                            r.byte_valid = 1'b1;
                            r.data_out = 8'(rd8(d + int'(idx)));
                        end
                    end
                    else
                        r.status = ST_NOTFOUND;
                end
                default:
                begin
                    if (find_record(int'(id), d, slen))
                        wr8(d - HDR_BYTES, MARK_FREE);
                    else
                        r.status = ST_NOTFOUND;
                end
            endcase
            expected_rsp.push_back(r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_response(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                report("unexpected beat", 0, 0);
                return;
            end
            want = expected_rsp.pop_front();
            if (got.status !== want.status)
                report("status", got.status, want.status);
            if (got.data_out !== want.data_out)
                report("data_out", got.data_out, want.data_out);
            if (got.byte_valid !== want.byte_valid)
                report("byte_valid", got.byte_valid, want.byte_valid);
            if (got.stored_length !== want.stored_length)
                report("stored_length", got.stored_length, want.stored_length);
        endtask
    endclass

    localparam int WATCHDOG_LIMIT = 30000;

    logic clk;
    logic rst_n;
    ers_req_if in_ch ();
    ers_rsp_if out_ch ();

    record_scoreboard sb;
    bit   no_idle;
    bit   staged_ok [STAGE_DEPTH];
    int   idle_cycles;
    logic [15:0] id_pool [6] = '{16'h0000, 16'h0001, 16'h0002, 16'h1234, 16'h8000, 16'hffff};

    eeprom_record_store dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task send_req(logic [1:0] kind, logic [15:0] id, logic [6:0] len,
                  logic [5:0] idx, logic [7:0] din);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.record_id <= id;
        in_ch.record_length <= len;
        in_ch.byte_index <= idx;
        in_ch.data_in <= din;
        forever
        begin
            @(posedge clk);
            if (in_ch.ready)
                break;
        end
        sb.note_request(kind, id, len, idx, din);
        if (kind == KIND_STAGE)
            staged_ok[idx] = 1'b1;
    endtask

    task stage(logic [5:0] idx, logic [7:0] din);
        send_req(KIND_STAGE, 16'h0, 7'd0, idx, din);
    endtask

    task wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    function int staged_prefix();
        for (int i = 0; i < STAGE_DEPTH; i++)
            if (!staged_ok[i])
                return i;
        return STAGE_DEPTH;
    endfunction

    function logic [15:0] pick_id();
        return ($urandom_range(0, 9) < 8) ? id_pool[$urandom_range(0, 5)]
                                          : 16'($urandom());
    endfunction

    task random_phase(int count);
        int n;
        int len;
        int sel;
        logic [15:0] id;
        n = 0;
        while (n < count)
        begin
            sel = $urandom_range(0, 99);
            id = pick_id();
            if (sel < 65)
            begin
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8)
                                                 : $urandom_range(9, MAX_LEN_DEF);
                for (int i = 0; i < len; i++)
                begin
                    if (!staged_ok[i] || $urandom_range(0, 2) != 0)
                    begin
                        stage(6'(i), 8'($urandom()));
                        n++;
                    end
                end
                send_req(KIND_COMMIT, id, 7'(len), 6'($urandom()), 8'($urandom()));
                n++;
                repeat ($urandom_range(0, 3))
                begin
                    send_req(KIND_READ, id, 7'($urandom_range(0, 127)),
                             6'($urandom_range(0, (len > 0) ? len : 1)), 8'($urandom()));
                    n++;
                end
            end
            else if (sel < 78)
                send_req(KIND_READ, id, 7'($urandom()), 6'($urandom()), 8'($urandom()));
            else if (sel < 88)
                send_req(KIND_FREE, id, 7'($urandom()), 6'($urandom()), 8'($urandom()));
            else if (sel < 94)
                stage(6'($urandom()), 8'($urandom()));
            else if (sel < 97)
                send_req(KIND_COMMIT, id, 7'($urandom_range(MAX_LEN_DEF + 1, 127)),
                         6'($urandom()), 8'($urandom()));
            else
                send_req(KIND_COMMIT, id, 7'($urandom_range(0, staged_prefix())),
                         6'($urandom()), 8'($urandom()));
            n++;
        end
    endtask

    initial
    begin
        sb = new();
        foreach (staged_ok[i])
            staged_ok[i] = 1'b0;
        no_idle = 1'b0;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.kind <= KIND_STAGE;
        in_ch.record_id <= '0;
        in_ch.record_length <= '0;
        in_ch.byte_index <= '0;
        in_ch.data_in <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // blank store gets formatted on first lookup
        send_req(KIND_READ, 16'h0000, 7'd64, 6'd0, 8'h00);
        send_req(KIND_FREE, 16'hffff, 7'd0, 6'd0, 8'h00);
        stage(6'd0, 8'h00);
        stage(6'd1, 8'hff);
        stage(6'd2, MARK_START);
        stage(6'd63, 8'h5a);
        send_req(KIND_COMMIT, 16'h0000, 7'd3, 6'd0, 8'h00);
        send_req(KIND_COMMIT, 16'hffff, 7'd3, 6'd63, 8'hff);
        send_req(KIND_READ, 16'h0000, 7'd64, 6'd0, 8'h00);
        send_req(KIND_READ, 16'h0000, 7'd2, 6'd2, 8'h00);
        send_req(KIND_READ, 16'hffff, 7'd127, 6'd63, 8'h00);
        send_req(KIND_READ, 16'hffff, 7'd127, 6'd2, 8'h00);
        send_req(KIND_COMMIT, 16'h0001, 7'd127, 6'd0, 8'h00);
        send_req(KIND_COMMIT, 16'h0001, 7'd65, 6'd0, 8'h00);
        send_req(KIND_COMMIT, 16'h0000, 7'd2, 6'd0, 8'h00);
        send_req(KIND_COMMIT, 16'h0000, 7'd3, 6'd0, 8'h00);
        send_req(KIND_READ, 16'h0000, 7'd3, 6'd1, 8'h00);
        send_req(KIND_FREE, 16'hffff, 7'd0, 6'd0, 8'h00);
        send_req(KIND_READ, 16'hffff, 7'd1, 6'd0, 8'h00);
        send_req(KIND_COMMIT, 16'hffff, 7'd0, 6'd0, 8'h00);
        // freeing the record at address 0 leaves the store unformatted
        send_req(KIND_FREE, 16'h0000, 7'd0, 6'd0, 8'h00);
        send_req(KIND_READ, 16'hffff, 7'd0, 6'd0, 8'h00);

        random_phase(90);
        wait_drained();
        no_idle = 1'b1;
        random_phase(60);
        no_idle = 1'b0;
        random_phase(130);
        in_ch.valid <= 1'b0;

        wait_drained();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.expected_rsp.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int hold;
        hold = 0;
        idle_cycles = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (out_ch.valid && out_ch.ready)
                sb.check_response(rsp_t'{out_ch.status, out_ch.data_out,
                                         out_ch.byte_valid, out_ch.stored_length});
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            if (no_idle)
                out_ch.ready <= 1'b1;
            else if (hold > 0)
            begin
                hold--;
                out_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 49) == 0)
            begin
                hold = $urandom_range(10, 40);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

endmodule
